// ===== rtl/string_to_integer_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// String to integer parser unit: assertion macros
// Shared immediate-consequence and next-cycle property forms.
// ----------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define S2I_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define S2I_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/s2i_pkg.sv =====
// ----------------------------------------------------------------------------
// s2i_pkg
// Types, character codes and helpers of the string to integer parser unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2i_pkg;

  localparam int unsigned PositionBitsDef = 16;
  localparam int unsigned ValueBits       = 64;
  localparam int unsigned BaseBits        = 6;
  localparam int unsigned CharBits        = 8;
  localparam int unsigned ApbDataBits     = 32;
  localparam int unsigned ApbAddrBits     = 2;

  localparam logic [ApbAddrBits-1:0] ADDR_BASE_SELECT = 2'd0;

  localparam logic [CharBits-1:0] CH_SPACE  = 8'h20;
  localparam logic [CharBits-1:0] CH_TAB    = 8'h09;
  localparam logic [CharBits-1:0] CH_CR     = 8'h0D;
  localparam logic [CharBits-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CharBits-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CharBits-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharBits-1:0] CH_NINE   = 8'h39;
  localparam logic [CharBits-1:0] CH_UP_A   = 8'h41;
  localparam logic [CharBits-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CharBits-1:0] CH_LO_A   = 8'h61;
  localparam logic [CharBits-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CharBits-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CharBits-1:0] CH_UP_X   = 8'h58;
  localparam logic [CharBits-1:0] CH_LO_X   = 8'h78;
  localparam logic [CharBits-1:0] CH_UP_O   = 8'h4F;
  localparam logic [CharBits-1:0] CH_LO_O   = 8'h6F;
  localparam logic [CharBits-1:0] CH_UP_B   = 8'h42;
  localparam logic [CharBits-1:0] CH_LO_B   = 8'h62;
  localparam logic [CharBits-1:0] CH_UP_U   = 8'h55;
  localparam logic [CharBits-1:0] CH_LO_U   = 8'h75;

  localparam logic [CharBits-1:0] UPPER_OFFSET = 8'd55;
  localparam logic [CharBits-1:0] LOWER_OFFSET = 8'd87;

  localparam logic [BaseBits-1:0] BASE_BIN = 6'd2;
  localparam logic [BaseBits-1:0] BASE_OCT = 6'd8;
  localparam logic [BaseBits-1:0] BASE_DEC = 6'd10;
  localparam logic [BaseBits-1:0] BASE_HEX = 6'd16;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_BSLASH = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic                ok;
    logic [BaseBits-1:0] val;
  } digit_t;

  function automatic digit_t decode_digit(input logic [CharBits-1:0] c);
    digit_t d;
    logic [CharBits-1:0] t;
    d = '0;
    t = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      d.ok = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - UPPER_OFFSET;
      d.ok = 1'b1;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - LOWER_OFFSET;
      d.ok = 1'b1;
    end
    d.val = t[BaseBits-1:0];
    return d;
  endfunction

  function automatic logic [BaseBits-1:0] pick_base(input logic [BaseBits-1:0] forced,
                                                    input logic [BaseBits-1:0] prefix);
    return (forced != '0) ? forced : prefix;
  endfunction

endpackage

// ===== rtl/string_to_integer_parser_unit.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser_unit
// Streaming strtol-style parser: one character per request, prefix and sign
// handling, 64-bit wrapping accumulate, one result per terminator.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | in_valid_i / in_ready_o    | character_i, end_of_string_i
//  out     | out_valid_o / out_ready_i  | value_o, stop_position_o
//  cfg     | psel penable pwrite pready | paddr, pwdata, prdata
//
//  One request per cycle unless a terminator waits in the input register;
//  a result is registered after its terminator leaves the input register.
//  The rate is set by the accumulate loop: one 64x6 multiply-add per cycle.
//  Reset clears all parse state and base_select to zero.
//  A terminator waits in the input register only while the result register
//  is full and not being taken; characters never wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_to_integer_parser_unit import s2i_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CharBits-1:0]      character_i,
  input  logic                     end_of_string_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueBits-1:0] value_o,
  output logic [POSITION_BITS-1:0] stop_position_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAddrBits-1:0]   paddr,
  input  logic [ApbDataBits-1:0]   pwdata,
  output logic [ApbDataBits-1:0]   prdata,
  output logic                     pready
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [BaseBits-1:0]      base_select_q;

  logic                     s1_valid_q;
  logic [CharBits-1:0]      s1_char_q;
  logic                     s1_eos_q;

  phase_e                   phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic [BaseBits-1:0]      base_q, base_d;
  logic [ValueBits-1:0]     acc_q, acc_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] end_q, end_d;

  logic                     out_valid_q, out_valid_d;
  logic [ValueBits-1:0]     out_value_q, out_value_d;
  logic [POSITION_BITS-1:0] out_stop_q, out_stop_d;

  logic                     out_free;
  logic                     s1_adv;
  logic                     cfg_wr;
  logic                     do_digit;
  logic [BaseBits-1:0]      tb;
  logic [POSITION_BITS-1:0] pos_inc;
  digit_t                   dig;
  logic [ValueBits-1:0]     mac;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_BASE_SELECT);
  assign prdata   = (paddr == ADDR_BASE_SELECT) ?
                    {{(ApbDataBits-BaseBits){1'b0}}, base_select_q} : '0;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_eos_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  assign pos_inc = (pos_q == PosMax) ? PosMax : pos_q + 1'b1;
  assign dig     = decode_digit(s1_char_q);
  assign mac     = acc_q * {{(ValueBits-BaseBits){1'b0}}, tb}
                 + {{(ValueBits-BaseBits){1'b0}}, dig.val};

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    base_d      = base_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    end_d       = end_q;
    out_value_d = out_value_q;
    out_stop_d  = out_stop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    do_digit    = 1'b0;
    tb          = base_q;

    if (s1_adv && s1_eos_q) begin
      out_valid_d = 1'b1;
      out_value_d = neg_q ? ('0 - acc_q) : acc_q;
      out_stop_d  = (phase_q == PH_ZERO) ? pos_q : end_q;
      phase_d     = PH_SPACE;
      neg_d       = 1'b0;
      base_d      = '0;
      acc_d       = '0;
      pos_d       = '0;
      end_d       = '0;
    end else if (s1_adv) begin
      pos_d = pos_inc;
      case (phase_q)
        PH_SPACE, PH_SIGNED: begin
          if (phase_q == PH_SPACE && s1_char_q inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
            phase_d = PH_SPACE;
          end else if (phase_q == PH_SPACE && s1_char_q inside {CH_PLUS, CH_MINUS}) begin
            neg_d   = (s1_char_q == CH_MINUS);
            phase_d = PH_SIGNED;
          end else if (s1_char_q == CH_ZERO) begin
            phase_d = PH_ZERO;
          end else if (s1_char_q == CH_BSLASH) begin
            phase_d = PH_BSLASH;
          end else begin
            tb       = pick_base(base_select_q, BASE_DEC);
            do_digit = 1'b1;
          end
        end
        PH_ZERO: begin
          phase_d = PH_DIGITS;
          if (s1_char_q inside {CH_LO_X, CH_UP_X}) begin
            base_d = pick_base(base_select_q, BASE_HEX);
          end else if (s1_char_q inside {CH_LO_O, CH_UP_O}) begin
            base_d = pick_base(base_select_q, BASE_OCT);
          end else if (s1_char_q inside {CH_LO_B, CH_UP_B}) begin
            base_d = pick_base(base_select_q, BASE_BIN);
          end else begin
            tb       = pick_base(base_select_q, BASE_DEC);
            do_digit = 1'b1;
          end
        end
        PH_BSLASH: begin
          phase_d = PH_DIGITS;
          if (s1_char_q inside {CH_LO_U, CH_UP_U, CH_LO_X, CH_UP_X}) begin
            base_d = pick_base(base_select_q, BASE_HEX);
          end else if (s1_char_q inside {CH_LO_O, CH_UP_O}) begin
            base_d = pick_base(base_select_q, BASE_OCT);
          end else if (s1_char_q inside {CH_LO_B, CH_UP_B}) begin
            base_d = pick_base(base_select_q, BASE_BIN);
          end else begin
            tb       = pick_base(base_select_q, BASE_OCT);
            do_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase

      if (do_digit) begin
        base_d = tb;
        if (dig.ok && (dig.val < tb)) begin
          acc_d   = mac;
          end_d   = pos_inc;
          phase_d = PH_DIGITS;
        end else begin
          end_d   = pos_q;
          phase_d = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_select_q <= '0;
    end else if (cfg_wr) begin
      base_select_q <= pwdata[BaseBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= character_i;
      s1_eos_q  <= end_of_string_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACE;
      neg_q       <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      base_q      <= base_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_stop_q  <= out_stop_d;
  end

  assign out_valid_o     = out_valid_q;
  assign value_o         = out_value_q;
  assign stop_position_o = out_stop_q;

endmodule

// ===== rtl/s2i_checker.sv =====
// ----------------------------------------------------------------------------
// s2i_checker
// Port-level checks of the string to integer parser unit, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "string_to_integer_parser_unit_defines.svh"

module s2i_checker import s2i_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     end_of_string_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [ValueBits-1:0]     value_o,
  input logic [POSITION_BITS-1:0] stop_position_o,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [ApbAddrBits-1:0]   paddr,
  input logic [ApbDataBits-1:0]   pwdata,
  input logic [ApbDataBits-1:0]   prdata
);

  `S2I_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(value_o) && $stable(stop_position_o), "result dropped or changed while stalled")
  `S2I_ASSERT_SAME(a_out_from_term, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o && end_of_string_i, 2), "result without a terminator two cycles before")
  `S2I_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty result register")
  `S2I_ASSERT_NEXT(a_cfg_readback, clk_i, rst_ni, psel && penable && pwrite && (paddr == ADDR_BASE_SELECT), (paddr != ADDR_BASE_SELECT) || (prdata[BaseBits-1:0] == $past(pwdata[BaseBits-1:0])), "base_select readback mismatch")

endmodule

bind string_to_integer_parser_unit s2i_checker #(
  .POSITION_BITS(POSITION_BITS)
) u_s2i_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .end_of_string_i(end_of_string_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .value_o        (value_o),
  .stop_position_o(stop_position_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

// ===== tb/string_to_integer_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser_unit_tb
// Streams strings one character per request, with and without sign, radix
// prefixes and trailing garbage, under several base_select settings and
// random idling on both channels. A scoreboard predicts each terminator's
// value and stop position and compares them with the results as they leave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_to_integer_parser_unit_tb import s2i_pkg::*;;

  localparam int unsigned PosBits    = PositionBitsDef;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainWait  = 6;
  localparam int unsigned PhaseItems = 88;
  localparam logic [PosBits-1:0] PosMax = '1;

  typedef struct {
    logic [ValueBits-1:0] value;
    logic [PosBits-1:0]   stop;
  } parse_result_t;

  class parse_scoreboard;
    logic [BaseBits-1:0]  base_sel;
    phase_e               parse_phase;
    logic                 negative;
    logic [BaseBits-1:0]  radix;
    logic [ValueBits-1:0] acc;
    logic [PosBits-1:0]   char_pos;
    logic [PosBits-1:0]   end_off;
    parse_result_t        expected_q[$];
    int unsigned          fails;

    function new();
      base_sel = '0;
      fails    = 0;
      clear();
    endfunction

    function void clear();
      parse_phase = PH_SPACE;
      negative    = 1'b0;
      radix       = '0;
      acc         = '0;
      char_pos    = '0;
      end_off     = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [PosBits-1:0] bump(logic [PosBits-1:0] p);
      return (p == PosMax) ? p : p + 1'b1;
    endfunction

    function void set_radix(logic [BaseBits-1:0] from_prefix);
      radix = (base_sel != '0) ? base_sel : from_prefix;
    endfunction

    function void take_digit(logic [CharBits-1:0] c, logic [PosBits-1:0] pos);
      int  v;
      bit  alnum;
      alnum = 1'b1;
      v     = 0;
      if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
      else if (c >= CH_UP_A && c <= CH_UP_Z) v = c - CH_UP_A + 10;
      else if (c >= CH_LO_A && c <= CH_LO_Z) v = c - CH_LO_A + 10;
      else alnum = 1'b0;
      if (alnum && v < int'(radix)) begin
        acc         = acc * ValueBits'(radix) + ValueBits'(v);
        end_off     = bump(pos);
        parse_phase = PH_DIGITS;
      end else begin
        end_off     = pos;
        parse_phase = PH_DONE;
      end
    endfunction

    function void take_leading_zero();
      acc     = acc * ValueBits'(radix);
      end_off = char_pos;
    endfunction

    function void begin_number(logic [CharBits-1:0] c, logic [PosBits-1:0] pos);
      if (c == CH_ZERO) begin
        parse_phase = PH_ZERO;
      end else if (c == CH_BSLASH) begin
        parse_phase = PH_BSLASH;
      end else begin
        set_radix(BASE_DEC);
        take_digit(c, pos);
      end
    endfunction

    function void note_request(logic [CharBits-1:0] c, logic eos);
      logic [PosBits-1:0] pos;
      parse_result_t      r;
      pos = char_pos;
      if (eos) begin
        if (parse_phase == PH_ZERO) begin
          set_radix(BASE_DEC);
          take_leading_zero();
        end
        r.value = negative ? -acc : acc;
        r.stop  = end_off;
        expected_q.push_back(r);
        clear();
        return;
      end
      case (parse_phase)
        PH_SPACE: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            negative    = (c == CH_MINUS);
            parse_phase = PH_SIGNED;
          end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            begin_number(c, pos);
          end
        end
        PH_SIGNED: begin_number(c, pos);
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            set_radix(BASE_HEX);
            parse_phase = PH_DIGITS;
          end else if (c == CH_LO_O || c == CH_UP_O) begin
            set_radix(BASE_OCT);
            parse_phase = PH_DIGITS;
          end else if (c == CH_LO_B || c == CH_UP_B) begin
            set_radix(BASE_BIN);
            parse_phase = PH_DIGITS;
          end else begin
            set_radix(BASE_DEC);
            take_leading_zero();
            take_digit(c, pos);
          end
        end
        PH_BSLASH: begin
          if (c == CH_LO_U || c == CH_UP_U || c == CH_LO_X || c == CH_UP_X) begin
            set_radix(BASE_HEX);
            parse_phase = PH_DIGITS;
          end else if (c == CH_LO_O || c == CH_UP_O) begin
            set_radix(BASE_OCT);
            parse_phase = PH_DIGITS;
          end else if (c == CH_LO_B || c == CH_UP_B) begin
            set_radix(BASE_BIN);
            parse_phase = PH_DIGITS;
          end else begin
            set_radix(BASE_OCT);
            take_digit(c, pos);
          end
        end
        PH_DIGITS: take_digit(c, pos);
        default: parse_phase = PH_DONE;
      endcase
      char_pos = bump(pos);
    endfunction

    function void check_result(logic [ValueBits-1:0] v, logic [PosBits-1:0] sp);
      parse_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: value %0d, stop_position %0d",
               $signed(v), sp);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (v !== e.value) begin
        $error("value: expected %0d, got %0d", $signed(e.value), $signed(v));
        fails++;
      end
      if (sp !== e.stop) begin
        $error("stop_position: expected %0d, got %0d", e.stop, sp);
        fails++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_ready_o;
  logic [CharBits-1:0]     character_i     = '0;
  logic                    end_of_string_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i     = 1'b0;
  logic signed [ValueBits-1:0] value_o;
  logic [PosBits-1:0]      stop_position_o;
  logic                    psel    = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite  = 1'b0;
  logic [ApbAddrBits-1:0]  paddr   = '0;
  logic [ApbDataBits-1:0]  pwdata  = '0;
  logic [ApbDataBits-1:0]  prdata;
  logic                    pready;

  parse_scoreboard board = new();
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     sent_count     = 0;
  int unsigned     cycles         = 0;
  int              base_now       = 0;
  int              base_plan[9]   = '{36, 2, 1, 63, 37, 16, 0, 8, 10};

  string_to_integer_parser_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .character_i     (character_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .value_o         (value_o),
    .stop_position_o (stop_position_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(value_o, stop_position_o);
    end
  end

  task automatic send_request(input logic [CharBits-1:0] c, input logic eos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    character_i     <= c;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(c, eos);
    sent_count++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ApbAddrBits-1:0] addr, input int data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ApbDataBits'(data);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.base_sel = BaseBits'(data);
    base_now       = data;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    send_request(CharBits'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random_string();
    int n, k, pfx, rdx, top, d;
    logic [CharBits-1:0] lead, letter;
    bit has_lead, has_letter, up;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(12);
      repeat (n) send_request(CharBits'($urandom_range(255)), 1'b0);
    end else begin
      repeat ($urandom_range(2)) begin
        k = $urandom_range(5);
        send_request((k == 0) ? CH_SPACE : CharBits'(8 + k), 1'b0);
      end
      k = $urandom_range(2);
      if (k == 1) send_request(CH_PLUS, 1'b0);
      else if (k == 2) send_request(CH_MINUS, 1'b0);
      pfx        = $urandom_range(11);
      up         = $urandom_range(1);
      rdx        = 10;
      has_lead   = 1'b1;
      has_letter = 1'b1;
      lead       = CH_BSLASH;
      letter     = '0;
      case (pfx)
        4: begin lead = CH_ZERO; letter = up ? CH_UP_X : CH_LO_X; rdx = 16; end
        5: begin lead = CH_ZERO; letter = up ? CH_UP_O : CH_LO_O; rdx = 8; end
        6: begin lead = CH_ZERO; letter = up ? CH_UP_B : CH_LO_B; rdx = 2; end
        7: begin letter = up ? CH_UP_U : CH_LO_U; rdx = 16; end
        8: begin letter = up ? CH_UP_X : CH_LO_X; rdx = 16; end
        9: begin letter = up ? CH_UP_O : CH_LO_O; rdx = 8; end
        10: begin letter = up ? CH_UP_B : CH_LO_B; rdx = 2; end
        11: begin has_letter = 1'b0; rdx = 8; end
        default: begin has_lead = 1'b0; has_letter = 1'b0; end
      endcase
      if (has_lead) send_request(lead, 1'b0);
      if (has_letter) send_request(letter, 1'b0);
      if (base_now != 0) rdx = base_now;
      top = (rdx > 36) ? 35 : rdx - 1;
      n   = ($urandom_range(3) == 0) ? $urandom_range(24, 7) : $urandom_range(6);
      repeat (n) begin
        d = $urandom_range(top);
        if (d < 10) send_request(CharBits'(CH_ZERO + d), 1'b0);
        else if ($urandom_range(1)) send_request(CharBits'(CH_UP_A + d - 10), 1'b0);
        else send_request(CharBits'(CH_LO_A + d - 10), 1'b0);
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) send_request(CharBits'($urandom_range(255)), 1'b0);
      end
    end
    send_request(CharBits'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int ph;
    int unsigned target;
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = 7;
    recv_stall_pct = 65;
    send_text("- 5");
    send_request(CH_ZERO, 1'b1);
    send_text("0");
    send_text("0x1g");
    send_text("\\b1");
    send_text("\\7");
    send_text("\t-0b1");
    send_request(CharBits'(8'hFF), 1'b0);
    send_request(CharBits'(8'h00), 1'b0);
    send_request(CharBits'(8'hFF), 1'b1);
    drain();

    for (ph = 0; ph < 9; ph++) begin
      send_idle_pct  = (ph < 3) ? 7 : (ph < 6) ? 65 : 0;
      recv_stall_pct = (ph < 3) ? 65 : (ph < 6) ? 7 : 0;
      apb_write(ADDR_BASE_SELECT, base_plan[ph]);
      target = sent_count + PhaseItems;
      while (sent_count < target) begin
        send_random_string();
        if (ph == 4 && !paused && sent_count + PhaseItems / 2 >= target) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    if (board.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/s2i_pkg.sv
rtl/string_to_integer_parser_unit.sv
rtl/s2i_checker.sv
tb/string_to_integer_parser_unit_tb.sv
